// ===== rtl/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types and fixed field widths of the TLB / page table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    localparam int ADDR_W    = 16;
    localparam int EVPAGE_W  = 8;
    localparam int CNT_W     = 32;
    localparam int RES_W     = ADDR_W + 3 + EVPAGE_W + 3 * CNT_W;
    localparam int RES_PAD_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic fill;
        logic inv;
    } t_tlb_ctl;

endpackage

// ===== rtl/tlbpt_tlb.sv =====
// ----------------------------------------------------------------------------
// tlbpt_tlb
// TLB storage with one shared tag comparator. One entry is read per cycle
// at the given slot; the compare acts on the registered read data.
// ----------------------------------------------------------------------------
module tlbpt_tlb #(
    parameter int PAGE_NUM_BITS  = 8,
    parameter int FRAME_NUM_BITS = 8,
    parameter int TLB_ENTRIES    = 16,
    parameter int IDX_W          = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tlbpt_pkg::t_tlb_ctl       i_ctl,
    input  logic [IDX_W-1:0]          i_idx,
    input  logic [PAGE_NUM_BITS-1:0]  i_key,
    input  logic [FRAME_NUM_BITS-1:0] i_fill_frame,
    output logic                      o_match,
    output logic [FRAME_NUM_BITS-1:0] o_frame
);

    logic [TLB_ENTRIES-1:0]    r_valid;
    logic [PAGE_NUM_BITS-1:0]  r_page_mem  [TLB_ENTRIES];
    logic [FRAME_NUM_BITS-1:0] r_frame_mem [TLB_ENTRIES];
    logic [PAGE_NUM_BITS-1:0]  r_rd_page;
    logic [FRAME_NUM_BITS-1:0] r_rd_frame;

    assign o_match = r_valid[i_idx] && (r_rd_page == i_key);
    assign o_frame = r_rd_frame;

    always_ff @(posedge i_clk) begin
        r_rd_page  <= r_page_mem[i_idx];
        r_rd_frame <= r_frame_mem[i_idx];
        if (i_ctl.fill) begin
            r_page_mem[i_idx]  <= i_key;
            r_frame_mem[i_idx] <= i_fill_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.fill) begin
            r_valid[i_idx] <= 1'b1;
        end else if (i_ctl.inv && o_match) begin
            r_valid[i_idx] <= 1'b0;
        end
    end

endmodule

// ===== rtl/tlb_page_table_translator_unit.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_translator_unit
// Logical to physical address translation with a FIFO-replaced TLB and
// demand paging with FIFO frame replacement.
// ----------------------------------------------------------------------------
// Slave stream: one logical address per transaction. Master stream: one
// result per transaction (physical address, flags, evicted page, counters).
// One translation is in flight at a time; s_axis_tready is high only while
// the sequencer waits for an address. The TLB is searched one slot at a
// time through a single comparator, a read state and a compare state per
// slot. A hit ends the search and goes to the output; a miss scans every
// slot and checks the page table. A resident page is then filled into the
// TLB, while a fault writes the page table before the fill, after a second
// scan that drops the victim's TLB entry when a frame is evicted. The
// result turns valid together with tready. After reset the page table
// valid bits are cleared one entry per cycle with tready low.
// The result sits in an output register; the next address is taken while
// it waits, and a finished translation holds until the register frees up.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_unit #(
    parameter int PAGE_NUM_BITS  = 8,
    parameter int OFFSET_WIDTH   = 8,
    parameter int FRAME_NUM_BITS = 8,
    parameter int TLB_ENTRIES    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] virtual address
    input  logic [tlbpt_pkg::ADDR_W-1:0]        i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] phys_addr, [16] tlb_hit, [17] page_fault, [18] evicted,
    // [26:19] evicted_page, [58:27] access_count, [90:59] tlb_miss_count,
    // [122:91] fault_count, upper bits zero
    output logic [tlbpt_pkg::RES_PAD_W-1:0]     o_m_axis_tdata
);

    localparam int IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int NPAGES = 1 << PAGE_NUM_BITS;
    localparam int NFRMS  = 1 << FRAME_NUM_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);
    localparam int CW = tlbpt_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_TRD, S_TCMP, S_PTCHK,
        S_IRD, S_ICMP, S_PTWR, S_FILL, S_OUT
    } t_state;

    t_state                    r_state;
    logic [PAGE_NUM_BITS-1:0]  r_clr_idx;
    logic [IDX_W-1:0]          r_idx;
    logic [IDX_W-1:0]          r_tlb_ptr;
    logic [PAGE_NUM_BITS-1:0]  r_page;
    logic [OFFSET_WIDTH-1:0]   r_offset;
    logic [FRAME_NUM_BITS-1:0] r_frame;
    logic [PAGE_NUM_BITS-1:0]  r_victim;
    logic                      r_hit;
    logic                      r_fault;
    logic                      r_evict;
    logic [FRAME_NUM_BITS-1:0] r_frame_ptr;
    logic                      r_all_used;
    logic [CW-1:0]             r_access_ctr;
    logic [CW-1:0]             r_miss_ctr;
    logic [CW-1:0]             r_fault_ctr;
    logic                      r_out_vld;
    logic [tlbpt_pkg::RES_PAD_W-1:0] r_out_data;

    logic [FRAME_NUM_BITS:0]   r_pt_mem    [NPAGES];
    logic [PAGE_NUM_BITS-1:0]  r_owner_mem [NFRMS];
    logic [FRAME_NUM_BITS:0]   r_pt_rd;
    logic [PAGE_NUM_BITS-1:0]  r_owner_rd;

    logic                      s_acc;
    logic [31:0]               addr_ext;
    logic [31:0]               pa_ext;
    logic [31:0]               evp_ext;
    logic                      pt_we;
    logic [PAGE_NUM_BITS-1:0]  pt_waddr;
    logic [FRAME_NUM_BITS:0]   pt_wdata;
    logic                      owner_we;
    tlbpt_pkg::t_tlb_ctl       tlb_ctl;
    logic [IDX_W-1:0]          tlb_idx;
    logic [PAGE_NUM_BITS-1:0]  tlb_key;
    logic                      tlb_match;
    logic [FRAME_NUM_BITS-1:0] tlb_frame;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    assign addr_ext = {16'b0, i_s_axis_tdata};
    assign pa_ext   = (32'(r_frame) << OFFSET_WIDTH) | 32'(r_offset);
    assign evp_ext  = r_evict ? 32'(r_victim) : 32'b0;

    // TLB control
    always_comb begin
        tlb_ctl.fill = (r_state == S_FILL);
        tlb_ctl.inv  = (r_state == S_ICMP);
        tlb_idx      = tlb_ctl.fill ? r_tlb_ptr : r_idx;
        tlb_key      = tlb_ctl.inv ? r_victim : r_page;
    end

    tlbpt_tlb #(
        .PAGE_NUM_BITS  (PAGE_NUM_BITS),
        .FRAME_NUM_BITS (FRAME_NUM_BITS),
        .TLB_ENTRIES    (TLB_ENTRIES),
        .IDX_W          (IDX_W)
    ) u_tlb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (tlb_ctl),
        .i_idx        (tlb_idx),
        .i_key        (tlb_key),
        .i_fill_frame (r_frame),
        .o_match      (tlb_match),
        .o_frame      (tlb_frame)
    );

    // page table / frame owner write port
    always_comb begin
        pt_we    = 1'b0;
        pt_waddr = r_page;
        pt_wdata = {1'b1, r_frame_ptr};
        owner_we = 1'b0;
        case (r_state)
            S_CLEAR: begin
                pt_we    = 1'b1;
                pt_waddr = r_clr_idx;
                pt_wdata = '0;
            end
            S_PTCHK: begin
                if (!r_pt_rd[FRAME_NUM_BITS] && r_all_used) begin
                    pt_we    = 1'b1;
                    pt_waddr = r_owner_rd;
                    pt_wdata = '0;
                end
            end
            S_PTWR: begin
                pt_we    = 1'b1;
                owner_we = 1'b1;
            end
            default: begin
                pt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pt_rd    <= r_pt_mem[r_page];
        r_owner_rd <= r_owner_mem[r_frame_ptr];
        if (pt_we) begin
            r_pt_mem[pt_waddr] <= pt_wdata;
        end
        if (owner_we) begin
            r_owner_mem[r_frame_ptr] <= r_page;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_idx        <= '0;
            r_tlb_ptr    <= '0;
            r_frame_ptr  <= '0;
            r_all_used   <= 1'b0;
            r_access_ctr <= '0;
            r_miss_ctr   <= '0;
            r_fault_ctr  <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (r_state != S_OUT && r_out_vld && i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_page       <= addr_ext[OFFSET_WIDTH +: PAGE_NUM_BITS];
                        r_offset     <= addr_ext[OFFSET_WIDTH-1:0];
                        r_hit        <= 1'b0;
                        r_fault      <= 1'b0;
                        r_evict      <= 1'b0;
                        r_victim     <= '0;
                        r_idx        <= '0;
                        r_access_ctr <= r_access_ctr + 1'b1;
                        r_state      <= S_TRD;
                    end
                end
                S_TRD: begin
                    r_state <= S_TCMP;
                end
                S_TCMP: begin
                    if (tlb_match) begin
                        r_hit   <= 1'b1;
                        r_frame <= tlb_frame;
                        r_state <= S_OUT;
                    end else if (r_idx == LAST_IDX) begin
                        r_miss_ctr <= r_miss_ctr + 1'b1;
                        r_state    <= S_PTCHK;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_TRD;
                    end
                end
                S_PTCHK: begin
                    if (r_pt_rd[FRAME_NUM_BITS]) begin
                        r_frame <= r_pt_rd[FRAME_NUM_BITS-1:0];
                        r_state <= S_FILL;
                    end else begin
                        r_fault     <= 1'b1;
                        r_fault_ctr <= r_fault_ctr + 1'b1;
                        r_frame     <= r_frame_ptr;
                        if (r_all_used) begin
                            r_evict  <= 1'b1;
                            r_victim <= r_owner_rd;
                            r_idx    <= '0;
                            r_state  <= S_IRD;
                        end else begin
                            r_state <= S_PTWR;
                        end
                    end
                end
                S_IRD: begin
                    r_state <= S_ICMP;
                end
                S_ICMP: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_PTWR;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_IRD;
                    end
                end
                S_PTWR: begin
                    r_frame_ptr <= r_frame_ptr + 1'b1;
                    if (r_frame_ptr == '1) begin
                        r_all_used <= 1'b1;
                    end
                    r_state <= S_FILL;
                end
                S_FILL: begin
                    r_tlb_ptr <= (r_tlb_ptr == LAST_IDX) ? '0 : r_tlb_ptr + 1'b1;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_vld || i_m_axis_tready) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= tlbpt_pkg::RES_PAD_W'({r_fault_ctr, r_miss_ctr,
                                      r_access_ctr, evp_ext[tlbpt_pkg::EVPAGE_W-1:0],
                                      r_evict, r_fault, r_hit,
                                      pa_ext[tlbpt_pkg::ADDR_W-1:0]});
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_ready_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_axis_tready)
        else $error("tready high during page table clear");

    a_access_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_access_ctr == $past(r_access_ctr) + 1'b1))
        else $error("access counter did not advance on accepted transaction");

    a_hit_not_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_data[16] && r_out_data[17]))
        else $error("result flags both hit and fault");

    a_evict_needs_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (!r_out_data[18] || r_out_data[17]))
        else $error("eviction without page fault");

    a_all_used_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_all_used))
        else $error("frames-in-use flag cleared outside reset");
`endif

endmodule
